// File: rtl/ragr_pkg.sv
// Shared types and constants for the rational accumulate / gcd reduce block.
// No dependencies; used by the controller, datapath, divider, top level and testbench.
package ragr_pkg;

	localparam int VW = 64;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_TYPE = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	// Datapath commands issued by the controller.
	typedef struct packed {
		logic load;      // load accumulator from operand
		logic mul_start; // start the cross products
		logic gcd_start; // narrow, fix signs, start Euclid
		logic div_start; // start the divisions by the gcd
		logic commit;    // write reduced pair to accumulator
	} dp_cmd_t;

	// Datapath status back to the controller.
	typedef struct packed {
		logic mul_done;
		logic gcd_done;
		logic gcd_zero;
		logic div_done;
	} dp_stat_t;

endpackage

// File: rtl/rational_accumulate_gcd_reduce.sv
// Rational fold with gcd reduction: the top level of the block.
// Uses ragr_pkg, ragr_ctrl and ragr_datapath.
//
// Usage: requests arrive on the in_ channel (valid/stall); each request
// carries one operand of a list, flagged first_of_list / last_of_list.
// A result request is given only for a request with last_of_list set.
// A skipped, first or error request runs no datapath sequence. A combined
// request runs the multiplies (three products of four 32x32 partial
// products each, one multiplier), then Euclid's loop of modulo steps on the
// shared bit-serial divider (up to about 92 steps), then, unless the gcd is
// zero, two back-to-back divisions by the gcd. The gcd loop sets the rate.
// One request is handled at a time; in_stall is high while it works.
// Reset clears the accumulator flags; no list is then loaded.
// When the receiver stalls, the result holds and no new request is taken
// until the result is taken.
module rational_accumulate_gcd_reduce (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic signed [63:0] operand_num,
	input  logic signed [63:0] operand_den,
	input  logic        first_of_list,
	input  logic        last_of_list,
	input  logic        operand_absent,
	input  logic        operand_not_number,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [63:0] result_num,
	output logic signed [63:0] result_den,
	output logic [1:0]  status
);
	ragr_pkg::dp_cmd_t  cmd;
	ragr_pkg::dp_stat_t stat;
	logic               ovf;
	logic [ragr_pkg::VW-1:0] acc_n, acc_d;

	ragr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.first_of_list(first_of_list), .last_of_list(last_of_list),
		.operand_absent(operand_absent), .operand_not_number(operand_not_number),
		.cmd(cmd), .stat(stat), .ovf(ovf), .acc_n(acc_n), .acc_d(acc_d),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_num(result_num), .result_den(result_den), .status(status)
	);

	ragr_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .op(req_type),
		.bn(operand_num), .bd(operand_den),
		.stat(stat), .ovf(ovf), .acc_n(acc_n), .acc_d(acc_d)
	);
endmodule

// File: rtl/ragr_divu.sv
// Iterative unsigned divider, one quotient bit per cycle.
// Depends on ragr_pkg for the value width.
module ragr_divu (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [ragr_pkg::VW-1:0]  dividend,
	input  logic [ragr_pkg::VW-1:0]  divisor,
	output logic                     done,
	output logic [ragr_pkg::VW-1:0]  quo,
	output logic [ragr_pkg::VW-1:0]  rem
);
	localparam int CW = $clog2(ragr_pkg::VW + 1);

	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic [ragr_pkg::VW-1:0]   dvs_q;
	logic [ragr_pkg::VW:0]     trial;

	// One restoring step on the shifted remainder.
	assign trial = {rem, quo[ragr_pkg::VW-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ragr_pkg::VW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo   <= dividend;
			rem   <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[ragr_pkg::VW]) begin
				rem <= trial[ragr_pkg::VW-1:0];
				quo <= {quo[ragr_pkg::VW-2:0], 1'b1};
			end else begin
				rem <= {rem[ragr_pkg::VW-2:0], quo[ragr_pkg::VW-1]};
				quo <= {quo[ragr_pkg::VW-2:0], 1'b0};
			end
		end
	end
endmodule

// File: rtl/ragr_datapath.sv
// Datapath: accumulator, sequential 32x32 multiplier, Euclid gcd and the
// final divisions. Depends on ragr_pkg and ragr_divu.
module ragr_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ragr_pkg::dp_cmd_t               cmd,
	input  logic [1:0]                      op,
	input  logic signed [ragr_pkg::VW-1:0]  bn,
	input  logic signed [ragr_pkg::VW-1:0]  bd,
	output ragr_pkg::dp_stat_t              stat,
	output logic                            ovf,
	output logic [ragr_pkg::VW-1:0]         acc_n,
	output logic [ragr_pkg::VW-1:0]         acc_d
);
	localparam int W = ragr_pkg::VW;
	localparam int W2 = 2 * W;

	logic [W-1:0] acc_n_q, acc_d_q;
	logic [W-1:0] bn_q, bd_q;
	logic [1:0]   op_q;

	// Product sequencer: three signed products, each as four 32x32 parts.
	logic [1:0]   prod_q;   // which product
	logic [1:0]   part_q;   // which partial product
	logic         mbusy_q;
	logic [W2-1:0] sum_q;   // current product being accumulated
	logic [W2-1:0] p0_q, p1_q, p2_q;
	logic [W-1:0] ma, mb;
	logic [W-1:0] mau, mbu;
	logic [31:0]  fa, fb;
	logic [63:0]  pp_s1;
	logic [1:0]   part_s1;
	logic         pv_s1, plast_s1;
	logic [1:0]   pprod_s1;
	logic         ma_neg_q, mb_neg_q;

	// Operand pair for each product.
	always_comb begin
		ma = acc_n_q;
		mb = bd_q;
		unique case (prod_q)
			2'd0: begin
				ma = acc_n_q;
				mb = (op_q == ragr_pkg::OP_MUL) ? bn_q : bd_q;
			end
			2'd1: begin
				ma = bn_q;
				mb = acc_d_q;
			end
			2'd2: begin
				ma = acc_d_q;
				mb = (op_q == ragr_pkg::OP_DIV) ? bn_q : bd_q;
			end
			default: begin
				ma = acc_d_q;
				mb = bd_q;
			end
		endcase
		mau = ma[W-1] ? (~ma + 1'b1) : ma;
		mbu = mb[W-1] ? (~mb + 1'b1) : mb;
		fa = part_q[0] ? mau[W-1:32] : mau[31:0];
		fb = part_q[1] ? mbu[W-1:32] : mbu[31:0];
	end

	logic [W2-1:0] shifted;
	logic [W2-1:0] prod_fin;
	always_comb begin
		shifted = W2'(pp_s1) << (32 * (int'(part_s1[0]) + int'(part_s1[1])));
		prod_fin = (ma_neg_q ^ mb_neg_q) ? (~(sum_q + shifted) + 1'b1)
		                                  : (sum_q + shifted);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			pv_s1   <= 1'b0;
		end else begin
			pv_s1 <= mbusy_q;
			if (cmd.mul_start) mbusy_q <= 1'b1;
			else if (mbusy_q && part_q == 2'd3 && prod_q == 2'd2) mbusy_q <= 1'b0;
		end
	end

	// Operand magnitudes: partial products, then signed sum per product.
	always_ff @(posedge clk) begin
		pp_s1    <= {32'd0, fa} * {32'd0, fb};
		part_s1  <= part_q;
		pprod_s1 <= prod_q;
		plast_s1 <= (part_q == 2'd3);
		if (cmd.mul_start) begin
			prod_q <= 2'd0;
			part_q <= 2'd0;
		end else if (mbusy_q) begin
			part_q <= part_q + 1'b1;
			if (part_q == 2'd3) prod_q <= prod_q + 1'b1;
		end
		if (mbusy_q && part_q == 2'd0) begin
			ma_neg_q <= ma[W-1];
			mb_neg_q <= mb[W-1];
		end
		if (pv_s1) begin
			if (plast_s1) begin
				sum_q <= '0;
				unique case (pprod_s1)
					2'd0: p0_q <= prod_fin;
					2'd1: p1_q <= prod_fin;
					default: p2_q <= prod_fin;
				endcase
			end else begin
				sum_q <= sum_q + shifted;
			end
		end else if (cmd.mul_start) begin
			sum_q <= '0;
		end
	end

	// Signs use the operands of the product in flight; capture aligns with the
	// first partial, and the finish uses the same product's flags.
	logic mdone_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mdone_q <= 1'b0;
		else mdone_q <= pv_s1 && plast_s1 && pprod_s1 == 2'd2;
	end
	assign stat.mul_done = mdone_q;

	// Combine products and narrow.
	logic [W2-1:0] wn, wd;
	always_comb begin
		unique case (op_q)
			ragr_pkg::OP_ADD: begin wn = p0_q + p1_q; wd = p2_q; end
			ragr_pkg::OP_SUB: begin wn = p0_q - p1_q; wd = p2_q; end
			ragr_pkg::OP_MUL: begin wn = p0_q; wd = p2_q; end
			default: begin wn = p0_q; wd = p2_q; end
		endcase
	end

	function automatic logic fits(input logic [W2-1:0] v);
		fits = (v[W2-1:W-1] == '0) || (v[W2-1:W-1] == '1);
	endfunction

	logic [W-1:0] nn_q, nd_q;
	logic         ovf_q;
	logic [W-1:0] ga_q, gb_q;
	logic         gbusy_q, gwait_q;
	logic         ddiv_q, dphase_q;
	logic [W-1:0] nsgn, dsgn, nneg, dneg;

	always_comb begin
		nneg = ~wn[W-1:0] + 1'b1;
		dneg = ~wd[W-1:0] + 1'b1;
		nsgn = (wn[W-1] && wd[W-1]) ? nneg : wn[W-1:0];
		dsgn = (wn[W-1] && wd[W-1]) ? dneg : wd[W-1:0];
	end

	// Shared divider for Euclid's steps and the final divisions.
	logic         dv_start, dv_done;
	logic [W-1:0] dv_a, dv_b, dv_q, dv_r;
	ragr_divu u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (dv_start),
		.dividend(dv_a),
		.divisor (dv_b),
		.done    (dv_done),
		.quo     (dv_q),
		.rem     (dv_r)
	);

	logic [W-1:0] magn, magd;
	assign magn = nn_q[W-1] ? (~nn_q + 1'b1) : nn_q;
	assign magd = nd_q[W-1] ? (~nd_q + 1'b1) : nd_q;

	logic gstep;
	assign gstep = gbusy_q && !gwait_q && gb_q != '0;
	always_comb begin
		dv_start = 1'b0;
		dv_a = ga_q;
		dv_b = gb_q;
		if (gstep) dv_start = 1'b1;
		else if (cmd.div_start) begin
			dv_start = 1'b1;
			dv_a = magn;
			dv_b = ga_q;
		end else if (ddiv_q && dv_done && !dphase_q) begin
			dv_start = 1'b1;
			dv_a = magd;
			dv_b = ga_q;
		end
	end

	logic gdone_q, ddone_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gbusy_q <= 1'b0;
			gwait_q <= 1'b0;
			ddiv_q  <= 1'b0;
			dphase_q <= 1'b0;
			gdone_q <= 1'b0;
			ddone_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			gdone_q <= 1'b0;
			ddone_q <= 1'b0;
			if (cmd.load) ovf_q <= 1'b0;
			if (cmd.gcd_start) begin
				gbusy_q <= 1'b1;
				gwait_q <= 1'b0;
				if (!fits(wn) || !fits(wd) ||
				    (wn[W-1] && wd[W-1] && (nneg[W-1] || dneg[W-1])))
					ovf_q <= 1'b1;
			end else if (gbusy_q) begin
				if (gstep) gwait_q <= 1'b1;
				else if (gwait_q && dv_done) gwait_q <= 1'b0;
				else if (!gwait_q && gb_q == '0) begin
					gbusy_q <= 1'b0;
					gdone_q <= 1'b1;
				end
			end
			if (cmd.div_start) begin
				ddiv_q <= 1'b1;
				dphase_q <= 1'b0;
			end else if (ddiv_q && dv_done) begin
				if (!dphase_q) dphase_q <= 1'b1;
				else begin
					ddiv_q  <= 1'b0;
					ddone_q <= 1'b1;
				end
			end
		end
	end

	logic [W-1:0] qn_q;
	always_ff @(posedge clk) begin
		if (cmd.gcd_start) begin
			nn_q <= nsgn;
			nd_q <= dsgn;
			ga_q <= (nsgn[W-1]) ? (~nsgn + 1'b1) : nsgn;
			gb_q <= (dsgn[W-1]) ? (~dsgn + 1'b1) : dsgn;
		end else if (gbusy_q && gwait_q && dv_done) begin
			ga_q <= gb_q;
			gb_q <= dv_r;
		end
		if (ddiv_q && dv_done && !dphase_q)
			qn_q <= nn_q[W-1] ? (~dv_q + 1'b1) : dv_q;
		if (cmd.load) begin
			acc_n_q <= bn;
			acc_d_q <= bd;
		end else if (cmd.commit) begin
			if (ga_q == '0) begin
				acc_n_q <= nn_q;
				acc_d_q <= nd_q;
			end else begin
				acc_n_q <= qn_q;
				acc_d_q <= nd_q[W-1] ? (~dv_q + 1'b1) : dv_q;
			end
		end
		if (cmd.mul_start) begin
			bn_q <= bn;
			bd_q <= bd;
			op_q <= op;
		end
	end

	assign stat.gcd_done = gdone_q;
	assign stat.gcd_zero = (ga_q == '0);
	assign stat.div_done = ddone_q;
	assign ovf   = ovf_q;
	assign acc_n = acc_n_q;
	assign acc_d = acc_d_q;
endmodule

// File: rtl/ragr_ctrl.sv
// Controller state machine: request decode, list flags, command sequencing
// and the result register. Depends on ragr_pkg.
module ragr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                first_of_list,
	input  logic                last_of_list,
	input  logic                operand_absent,
	input  logic                operand_not_number,
	output ragr_pkg::dp_cmd_t   cmd,
	input  ragr_pkg::dp_stat_t  stat,
	input  logic                ovf,
	input  logic [ragr_pkg::VW-1:0] acc_n,
	input  logic [ragr_pkg::VW-1:0] acc_d,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [63:0]         result_num,
	output logic [63:0]         result_den,
	output logic [1:0]          status
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_GCD  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q;
	logic       terr_q, loaded_q, last_q;
	logic       acc;

	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);
	assign acc = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		cmd.load = acc && first_of_list && !operand_absent && !operand_not_number;
		cmd.mul_start = acc && !first_of_list && loaded_q && !operand_absent &&
		                !operand_not_number && !terr_q;
		cmd.gcd_start = (state_q == S_MUL) && stat.mul_done;
		cmd.div_start = (state_q == S_GCD) && stat.gcd_done && !stat.gcd_zero;
		cmd.commit = (state_q == S_DONE);
	end

	// Sequencing of one combine, and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			terr_q     <= 1'b0;
			loaded_q   <= 1'b0;
			last_q     <= 1'b0;
			out_valid  <= 1'b0;
			result_num <= '0;
			result_den <= '0;
			status     <= ragr_pkg::ST_OK;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (acc) begin
					last_q <= last_of_list;
					if (first_of_list) begin
						terr_q   <= operand_absent || operand_not_number;
						loaded_q <= 1'b1;
					end else if (!loaded_q || (operand_not_number && !operand_absent))
						terr_q <= 1'b1;
					if (cmd.mul_start) state_q <= S_MUL;
					else if (last_of_list) state_q <= S_OUT;
				end
				S_MUL: if (stat.mul_done) state_q <= S_GCD;
				S_GCD: if (stat.gcd_done) state_q <= stat.gcd_zero ? S_DONE : S_DIV;
				S_DIV: if (stat.div_done) state_q <= S_DONE;
				S_DONE: state_q <= last_q ? S_OUT : S_IDLE;
				S_OUT: begin
					out_valid <= 1'b1;
					loaded_q  <= 1'b0;
					if (terr_q) begin
						result_num <= '0;
						result_den <= '0;
						status     <= ragr_pkg::ST_TYPE;
					end else begin
						result_num <= 64'(signed'(acc_n));
						result_den <= 64'(signed'(acc_d));
						status     <= ovf ? ragr_pkg::ST_OVF : ragr_pkg::ST_OK;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: sim/ragr_checker.sv
// Checker for the rational fold block: watches the request and result channels,
// predicts each result with its own rational fold and compares.
// Depends on ragr_pkg for operation and status codes.
`timescale 1ns / 1ps

module ragr_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic signed [63:0] operand_num,
	input  logic signed [63:0] operand_den,
	input  logic              first_of_list,
	input  logic              last_of_list,
	input  logic              operand_absent,
	input  logic              operand_not_number,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic signed [63:0] result_num,
	input  logic signed [63:0] result_den,
	input  logic [1:0]        status,
	output int                fail_count,
	output int                awaiting
);
	typedef struct {
		logic signed [63:0] num;
		logic signed [63:0] den;
		logic [1:0]         st;
	} fold_result_t;

	fold_result_t pending_results[$];

	logic signed [63:0] acc_num, acc_den;
	logic list_bad, list_ovf, list_open;
	int   n_fail;

	function automatic logic signed [127:0] widen(input logic signed [63:0] x);
		return 128'(x);
	endfunction

	// Cross-multiply the accumulator with one operand, narrow, then reduce by the gcd.
	task automatic combine_operand(input logic [1:0] op, input logic signed [63:0] bn,
			input logic signed [63:0] bd);
		logic signed [127:0] wn, wd;
		logic signed [63:0] n, d;
		logic [63:0] mn, md, a, b, t;
		case (op)
			ragr_pkg::OP_ADD: begin
				wn = widen(acc_num) * widen(bd) + widen(bn) * widen(acc_den);
				wd = widen(acc_den) * widen(bd);
			end
			ragr_pkg::OP_SUB: begin
				wn = widen(acc_num) * widen(bd) - widen(bn) * widen(acc_den);
				wd = widen(acc_den) * widen(bd);
			end
			ragr_pkg::OP_MUL: begin
				wn = widen(acc_num) * widen(bn);
				wd = widen(acc_den) * widen(bd);
			end
			default: begin
				wn = widen(acc_num) * widen(bd);
				wd = widen(acc_den) * widen(bn);
			end
		endcase
		n = wn[63:0];
		d = wd[63:0];
		if (widen(n) != wn || widen(d) != wd)
			list_ovf = 1'b1;
		// Two negative parts are negated; the most negative value overflows.
		if (n < 0 && d < 0) begin
			n = -n;
			d = -d;
			if (n < 0 || d < 0)
				list_ovf = 1'b1;
		end
		mn = (n < 0) ? -n : n;
		md = (d < 0) ? -d : d;
		a = mn;
		b = md;
		while (b != 0) begin
			t = b;
			b = a % b;
			a = t;
		end
		// A zero gcd leaves the pair as it is.
		if (a != 0) begin
			n = (n < 0) ? -(mn / a) : (mn / a);
			d = (d < 0) ? -(md / a) : (md / a);
		end
		acc_num = n;
		acc_den = d;
	endtask

	// Apply one accepted request to the predicted state.
	task automatic fold_request();
		fold_result_t r;
		if (first_of_list) begin
			list_ovf = 1'b0;
			list_bad = operand_absent || operand_not_number;
			if (!list_bad) begin
				acc_num = operand_num;
				acc_den = operand_den;
			end
			list_open = 1'b1;
		end else if (!list_open) begin
			list_bad = 1'b1;
		end else if (operand_absent) begin
			// A null element is skipped.
		end else if (operand_not_number) begin
			list_bad = 1'b1;
		end else if (!list_bad) begin
			combine_operand(req_type, operand_num, operand_den);
		end
		if (last_of_list) begin
			if (list_bad) begin
				r.num = '0;
				r.den = '0;
				r.st = ragr_pkg::ST_TYPE;
			end else begin
				r.num = acc_num;
				r.den = acc_den;
				r.st = list_ovf ? ragr_pkg::ST_OVF : ragr_pkg::ST_OK;
			end
			pending_results.push_back(r);
			list_open = 1'b0;
		end
	endtask

	// Compare one accepted result request with the oldest prediction.
	task automatic check_result();
		fold_result_t r;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result num=%0d den=%0d status=%0d",
				$time, result_num, result_den, status);
			n_fail++;
		end else begin
			r = pending_results.pop_front();
			if (result_num !== r.num) begin
				$display("%0t: result_num expected %0d actual %0d", $time, r.num, result_num);
				n_fail++;
			end
			if (result_den !== r.den) begin
				$display("%0t: result_den expected %0d actual %0d", $time, r.den, result_den);
				n_fail++;
			end
			if (status !== r.st) begin
				$display("%0t: status expected %0d actual %0d", $time, r.st, status);
				n_fail++;
			end
		end
	endtask

	// Both channels are sampled at the clock edge where they hand over.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_num = 64'sd0;
			acc_den = 64'sd1;
			list_bad = 1'b0;
			list_ovf = 1'b0;
			list_open = 1'b0;
			n_fail = 0;
			pending_results.delete();
			fail_count <= 0;
			awaiting <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				fold_request();
			fail_count <= n_fail;
			awaiting <= pending_results.size();
		end
	end

endmodule

// File: sim/tb.sv
// Testbench top for the rational fold block: clock, reset, request stimulus,
// result stalls, watchdog and verdict. Depends on ragr_pkg, ragr_checker and the RTL.
`timescale 1ns / 1ps

module tb;
	localparam int WATCHDOG_LIMIT = 60000;
	localparam int REQ_TARGET = 750;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = ragr_pkg::OP_ADD;
	logic signed [63:0] operand_num = '0;
	logic signed [63:0] operand_den = '0;
	logic first_of_list = 1'b0;
	logic last_of_list = 1'b0;
	logic operand_absent = 1'b0;
	logic operand_not_number = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [63:0] result_num, result_den;
	logic [1:0] status;

	int fail_count, awaiting;
	int idle_cycles = 0;
	int burst_left = 0;
	bit valid_held = 1'b0;
	int stall_mode = 0;
	int stall_phase = 0;

	localparam logic signed [63:0] VMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] VMIN = 64'sh8000_0000_0000_0000;

	rational_accumulate_gcd_reduce uut (.*);

	ragr_checker checker_i (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// The receiver alternates between free flow, random stalls and heavy stalls.
	always @(posedge clk) begin
		if (stall_phase == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_phase = $urandom_range(50, 400);
		end else begin
			stall_phase--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// The watchdog ends the run when no request or result moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Mostly small magnitudes keep Euclid short; wide and extreme values still appear.
	function automatic logic signed [63:0] pick_value();
		logic signed [63:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: v = 64'($urandom_range(0, 200));
			6, 7: v = 64'($signed($urandom));
			8: v = {$urandom, $urandom};
			default: begin
				case ($urandom_range(0, 4))
					0: v = VMAX;
					1: v = VMIN;
					2: v = 64'sd0;
					3: v = 64'sd1;
					default: v = -64'sd1;
				endcase
			end
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// Send one request and hold it until accepted; then maybe leave a gap.
	task automatic send_req(input logic [1:0] op, input logic signed [63:0] n,
			input logic signed [63:0] d, input logic f, input logic l,
			input logic ab, input logic nn);
		in_valid <= 1'b1;
		valid_held = 1'b1;
		req_type <= op;
		operand_num <= n;
		operand_den <= d;
		first_of_list <= f;
		last_of_list <= l;
		operand_absent <= ab;
		operand_not_number <= nn;
		do @(posedge clk); while (in_stall);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 20);
		end else begin
			burst_left--;
		end
	endtask

	// Hold the sender off until every predicted result has arrived.
	task automatic drain_results();
		if (valid_held) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
		end
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
	endtask

	initial begin
		int sent;
		int len;
		bit paused;
		logic f, l, ab, nn;
		sent = 0;
		paused = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lists: a request with no list loaded, every operation,
		// overflow, negation of the most negative value, errors, zero pairs.
		send_req(ragr_pkg::OP_ADD, 64'sd2, 64'sd3, 1'b0, 1'b1, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_ADD, 64'sd5, 64'sd3, 1'b1, 1'b0, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_ADD, -64'sd7, 64'sd4, 1'b0, 1'b1, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_ADD, 64'sd1, 64'sd2, 1'b1, 1'b0, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_SUB, 64'sd1, 64'sd3, 1'b0, 1'b0, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_MUL, 64'sd3, 64'sd4, 1'b0, 1'b0, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_DIV, 64'sd5, -64'sd6, 1'b0, 1'b1, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_ADD, VMAX, 64'sd1, 1'b1, 1'b0, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_MUL, VMAX, 64'sd1, 1'b0, 1'b1, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_ADD, VMIN, -64'sd1, 1'b1, 1'b0, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_MUL, 64'sd1, 64'sd1, 1'b0, 1'b1, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_SUB, 64'sd9, 64'sd9, 1'b1, 1'b1, 1'b1, 1'b0);
		send_req(ragr_pkg::OP_ADD, 64'sd0, 64'sd0, 1'b1, 1'b0, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_ADD, 64'sd0, 64'sd0, 1'b0, 1'b1, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_MUL, 64'sd4, 64'sd6, 1'b1, 1'b0, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_MUL, 64'sd1, 64'sd1, 1'b0, 1'b0, 1'b1, 1'b0);
		send_req(ragr_pkg::OP_DIV, 64'sd1, 64'sd1, 1'b0, 1'b1, 1'b0, 1'b1);
		send_req(ragr_pkg::OP_DIV, 64'sd3, 64'sd0, 1'b1, 1'b1, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_MUL, 64'sd6, 64'sd4, 1'b1, 1'b0, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_DIV, 64'sd0, 64'sd5, 1'b0, 1'b1, 1'b0, 1'b0);
		send_req(ragr_pkg::OP_DIV, VMIN, VMAX, 1'b1, 1'b0, 1'b0, 1'b1);
		send_req(ragr_pkg::OP_SUB, VMIN, VMIN, 1'b0, 1'b1, 1'b0, 1'b0);

		// Random lists with random content, plus some stray requests.
		while (sent < REQ_TARGET) begin
			if (!paused && sent >= REQ_TARGET / 2) begin
				drain_results();
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) == 0) begin
				ab = 1'($urandom_range(0, 1));
				send_req(2'($urandom_range(0, 3)), pick_value(), pick_value(),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), ab,
					1'($urandom_range(0, 1)));
				sent++;
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					f = (i == 0);
					l = (i == len - 1);
					ab = (i > 0) && ($urandom_range(0, 9) == 0);
					nn = ($urandom_range(0, 29) == 0);
					send_req(2'($urandom_range(0, 3)), pick_value(), pick_value(),
						f, l, ab, nn);
					if (!ab)
						sent++;
				end
			end
		end
		// Close with a complete list so the block ends idle.
		send_req(ragr_pkg::OP_ADD, 64'sd1, 64'sd2, 1'b1, 1'b1, 1'b0, 1'b0);

		drain_results();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && awaiting == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
